FILE: hdl/tcw_pkg.sv
// Shared types, constants and helper functions for the text console writer.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int ADDR_W  = $clog2(CELL_COUNT);
	localparam int KIND_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int INDEX_W = 11;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;

	typedef logic [COL_W-1:0]   col_t;
	typedef logic [COL_W:0]     colx_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [ROW_W:0]     rowx_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [KIND_W-1:0]  kind_t;

	localparam kind_t KIND_PUT   = 2'd0;
	localparam kind_t KIND_READ  = 2'd1;
	localparam kind_t KIND_CLEAR = 2'd2;

	localparam char_t CHAR_BS    = 8'h08;
	localparam char_t CHAR_TAB   = 8'h09;
	localparam char_t CHAR_LF    = 8'h0A;
	localparam char_t CHAR_CR    = 8'h0D;
	localparam char_t CHAR_SPACE = 8'h20;
	localparam char_t CHAR_LAST  = 8'h7F;

	localparam int     TAB_STEP    = 8;
	localparam color_t COLOR_RESET = 8'h07;
	localparam cell_t  RESET_BLANK = {COLOR_RESET, CHAR_SPACE};

	localparam addr_t ADDR_LAST   = addr_t'(CELL_COUNT - 1);
	localparam addr_t ADDR_ROW1   = addr_t'(COLUMNS);
	localparam addr_t ADDR_BOTTOM = addr_t'(CELL_COUNT - COLUMNS);

	function automatic addr_t cell_addr(row_t row, col_t col);
		return addr_t'(row) * addr_t'(COLUMNS) + addr_t'(col);
	endfunction

endpackage

FILE: hdl/text_console_writer.sv
// Text console writer: cell store, cursor logic and the scroll and clear sequencer.
//
// The screen is a ROWS x COLUMNS store of 16-bit cells (attribute high byte, character
// low byte) held in one synchronous RAM with one write and one read port. After reset a
// clearing pass fills the store with blanks; input words are stalled meanwhile, while
// color writes are taken at any time. A put word that only moves the cursor or writes one
// cell, and an unused kind, go straight to the result; a read first waits in a read state
// for the RAM read data. A clear fills the store, one cell written per cycle. A put that
// passes the last row scrolls: it copies rows up through the RAM (one read and one write
// per cycle), then blanks the bottom row, then gives the result. Results leave through an
// output register, so the next word is accepted while a result waits to be taken.
module text_console_writer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [tcw_pkg::COLOR_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tcw_pkg::KIND_W-1:0]  kind,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tcw_pkg::POS_W-1:0]   cursor_position,
	output logic [tcw_pkg::CELL_W-1:0]  cell_value
);

	typedef enum logic [5:0] {
		S_INIT = 6'b000001,
		S_IDLE = 6'b000010,
		S_READ = 6'b000100,
		S_COPY = 6'b001000,
		S_FILL = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                state_q;
	tcw_pkg::color_t       color_q;
	tcw_pkg::col_t         col_q;
	tcw_pkg::row_t         row_q;
	tcw_pkg::addr_t        addr_q;
	tcw_pkg::cell_t        fill_cell_q;
	tcw_pkg::cell_t        result_cell_q;
	logic                  oob_q;
	logic                  copy_pend_s1;
	tcw_pkg::addr_t        copy_addr_s1;
	tcw_pkg::cell_t        rd_data_q;
	logic                  out_valid_q;
	logic [tcw_pkg::POS_W-1:0] cursor_position_q;
	tcw_pkg::cell_t        cell_value_q;

	tcw_pkg::cell_t        mem [tcw_pkg::CELL_COUNT];

	logic                  accept;
	logic                  oob;
	logic                  put_write;
	logic                  lf;
	logic                  wrap;
	logic                  scroll;
	tcw_pkg::colx_t        col_ext;
	tcw_pkg::colx_t        col_nx;
	tcw_pkg::rowx_t        row_nx;
	tcw_pkg::col_t         col_fin;
	tcw_pkg::row_t         row_fin;
	logic                  wr_en;
	tcw_pkg::addr_t        wr_addr;
	tcw_pkg::cell_t        wr_data;
	tcw_pkg::addr_t        rd_addr;

	assign in_stall        = (state_q != S_IDLE);
	assign accept          = in_valid && !in_stall;
	assign out_valid       = out_valid_q;
	assign cursor_position = cursor_position_q;
	assign cell_value      = cell_value_q;
	assign oob             = (cell_index >= tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT));

	always_comb begin
		col_ext   = {1'b0, col_q};
		col_nx    = col_ext;
		lf        = 1'b0;
		put_write = 1'b0;
		case (char_code)
			tcw_pkg::CHAR_BS: begin
				if (col_q != '0) begin
					col_nx = col_ext - 1'b1;
				end
			end
			tcw_pkg::CHAR_TAB: begin
				col_nx = (col_ext + tcw_pkg::colx_t'(tcw_pkg::TAB_STEP))
					& ~tcw_pkg::colx_t'(tcw_pkg::TAB_STEP - 1);
			end
			tcw_pkg::CHAR_CR: begin
				col_nx = '0;
			end
			tcw_pkg::CHAR_LF: begin
				col_nx = '0;
				lf     = 1'b1;
			end
			default: begin
				if (char_code inside {[tcw_pkg::CHAR_SPACE:tcw_pkg::CHAR_LAST]}) begin
					put_write = 1'b1;
					col_nx    = col_ext + 1'b1;
				end
			end
		endcase
		wrap    = (col_nx >= tcw_pkg::colx_t'(tcw_pkg::COLUMNS));
		row_nx  = {1'b0, row_q} + tcw_pkg::rowx_t'(lf) + tcw_pkg::rowx_t'(wrap);
		scroll  = (row_nx >= tcw_pkg::rowx_t'(tcw_pkg::ROWS));
		col_fin = wrap ? '0 : col_nx[tcw_pkg::COL_W-1:0];
		row_fin = scroll ? tcw_pkg::row_t'(tcw_pkg::ROWS - 1) : row_nx[tcw_pkg::ROW_W-1:0];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = fill_cell_q;
		if (copy_pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = copy_addr_s1;
			wr_data = rd_data_q;
		end else if (state_q == S_INIT) begin
			wr_en   = 1'b1;
			wr_data = tcw_pkg::RESET_BLANK;
		end else if (state_q == S_FILL) begin
			wr_en   = 1'b1;
		end else if (accept && kind == tcw_pkg::KIND_PUT && put_write) begin
			wr_en   = 1'b1;
			wr_addr = tcw_pkg::cell_addr(row_q, col_q);
			wr_data = {color_q, char_code};
		end
		if (state_q == S_COPY) begin
			rd_addr = addr_q;
		end else if (oob) begin
			rd_addr = '0;
		end else begin
			rd_addr = cell_index[tcw_pkg::ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_INIT;
			color_q           <= tcw_pkg::COLOR_RESET;
			col_q             <= '0;
			row_q             <= '0;
			addr_q            <= '0;
			fill_cell_q       <= tcw_pkg::RESET_BLANK;
			result_cell_q     <= '0;
			oob_q             <= 1'b0;
			copy_pend_s1      <= 1'b0;
			copy_addr_s1      <= '0;
			out_valid_q       <= 1'b0;
			cursor_position_q <= '0;
			cell_value_q      <= '0;
		end else begin
			if (cfg_write) begin
				color_q <= cfg_data;
			end
			copy_pend_s1 <= (state_q == S_COPY);
			copy_addr_s1 <= addr_q - tcw_pkg::ADDR_ROW1;
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (addr_q == tcw_pkg::ADDR_LAST) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						result_cell_q <= '0;
						case (kind)
							tcw_pkg::KIND_PUT: begin
								col_q <= col_fin;
								row_q <= row_fin;
								if (scroll) begin
									addr_q  <= tcw_pkg::ADDR_ROW1;
									state_q <= S_COPY;
								end else begin
									state_q <= S_DONE;
								end
							end
							tcw_pkg::KIND_READ: begin
								oob_q   <= oob;
								state_q <= S_READ;
							end
							tcw_pkg::KIND_CLEAR: begin
								col_q       <= '0;
								row_q       <= '0;
								fill_cell_q <= {color_q, tcw_pkg::CHAR_SPACE};
								addr_q      <= '0;
								state_q     <= S_FILL;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					result_cell_q <= oob_q ? '0 : rd_data_q;
					state_q       <= S_DONE;
				end
				S_COPY: begin
					if (addr_q == tcw_pkg::ADDR_LAST) begin
						addr_q      <= tcw_pkg::ADDR_BOTTOM;
						fill_cell_q <= {color_q, tcw_pkg::CHAR_SPACE};
						state_q     <= S_FILL;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_FILL: begin
					if (!copy_pend_s1) begin
						if (addr_q == tcw_pkg::ADDR_LAST) begin
							state_q <= S_DONE;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q       <= 1'b1;
						cursor_position_q <= tcw_pkg::POS_W'(tcw_pkg::cell_addr(row_q, col_q));
						cell_value_q      <= result_cell_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/tcw_checker.sv
// Port-level assertions for the text console writer and the bind that attaches them.
module tcw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [tcw_pkg::POS_W-1:0]   cursor_position,
	input logic [tcw_pkg::CELL_W-1:0]  cell_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cursor_position) && $stable(cell_value))
		else $error("stalled result word changed");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_position < tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT))
		else $error("cursor position outside the screen");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input word accepted while the previous one is still in work");

	a_init_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input word accepted during the clearing pass");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

FILE: sim/text_console_writer_checker.sv
`timescale 1ns / 100ps
// Checker for the text console writer: tracks the screen and cursor and compares every result.
module text_console_writer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tcw_pkg::KIND_W-1:0]    kind,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tcw_pkg::POS_W-1:0]     cursor_position,
	input  logic [tcw_pkg::CELL_W-1:0]    cell_value,
	output int                            mismatch_count,
	output int                            results_taken
);

	typedef struct packed {
		logic [tcw_pkg::POS_W-1:0] position;
		tcw_pkg::cell_t            value;
	} console_reply_t;

	tcw_pkg::cell_t  shadow_screen [tcw_pkg::CELL_COUNT];
	int unsigned     cursor_col;
	int unsigned     cursor_row;
	tcw_pkg::color_t attr_color;
	console_reply_t  expected_replies [$];

	function automatic void blank_screen();
		for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
			shadow_screen[i] = {attr_color, tcw_pkg::CHAR_SPACE};
		cursor_col = 0;
		cursor_row = 0;
	endfunction

	function automatic void scroll_screen();
		for (int i = tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
			shadow_screen[i - tcw_pkg::COLUMNS] = shadow_screen[i];
		for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
			shadow_screen[i] = {attr_color, tcw_pkg::CHAR_SPACE};
	endfunction

	function automatic void put_char(tcw_pkg::char_t c);
		if (c == tcw_pkg::CHAR_BS) begin
			if (cursor_col > 0)
				cursor_col--;
		end else if (c == tcw_pkg::CHAR_TAB) begin
			cursor_col = (cursor_col / tcw_pkg::TAB_STEP + 1) * tcw_pkg::TAB_STEP;
		end else if (c == tcw_pkg::CHAR_CR) begin
			cursor_col = 0;
		end else if (c == tcw_pkg::CHAR_LF) begin
			cursor_col = 0;
			cursor_row++;
		end else if (c >= tcw_pkg::CHAR_SPACE && c <= tcw_pkg::CHAR_LAST) begin
			shadow_screen[cursor_row * tcw_pkg::COLUMNS + cursor_col] = {attr_color, c};
			cursor_col++;
		end
		if (cursor_col >= tcw_pkg::COLUMNS) begin
			cursor_col = 0;
			cursor_row++;
		end
		if (cursor_row >= tcw_pkg::ROWS) begin
			scroll_screen();
			cursor_row = tcw_pkg::ROWS - 1;
		end
	endfunction

	function automatic console_reply_t next_reply(tcw_pkg::kind_t k, tcw_pkg::char_t c,
		logic [tcw_pkg::INDEX_W-1:0] idx);
		console_reply_t r;
		r.value = '0;
		case (k)
			tcw_pkg::KIND_PUT: put_char(c);
			tcw_pkg::KIND_READ: begin
				if (idx < tcw_pkg::CELL_COUNT)
					r.value = shadow_screen[idx];
			end
			tcw_pkg::KIND_CLEAR: blank_screen();
			default: ;
		endcase
		r.position = tcw_pkg::POS_W'(cursor_row * tcw_pkg::COLUMNS + cursor_col);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_reply_t want;
		if (!arst_n) begin
			attr_color = tcw_pkg::COLOR_RESET;
			blank_screen();
			expected_replies.delete();
			mismatch_count = 0;
			results_taken <= 0;
		end else begin
			if (cfg_write)
				attr_color = cfg_data;
			if (out_valid && !out_stall) begin
				results_taken <= results_taken + 1;
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected word, position %0d cell %h", $time,
						cursor_position, cell_value);
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (cursor_position !== want.position) begin
						$display("%0t: cursor_position expected %0d actual %0d", $time,
							want.position, cursor_position);
						mismatch_count++;
					end
					if (cell_value !== want.value) begin
						$display("%0t: cell_value expected %h actual %h", $time,
							want.value, cell_value);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_replies.push_back(next_reply(kind, char_code, cell_index));
		end
	end

endmodule

FILE: sim/text_console_writer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the text console writer: stimulus, stalls, color writes and the verdict.
module text_console_writer_tb;

	localparam tcw_pkg::kind_t KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_WORDS = 280;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write;
	logic [tcw_pkg::COLOR_W-1:0]   cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [tcw_pkg::KIND_W-1:0]    kind;
	logic [tcw_pkg::CHAR_W-1:0]    char_code;
	logic [tcw_pkg::INDEX_W-1:0]   cell_index;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [tcw_pkg::POS_W-1:0]     cursor_position;
	logic [tcw_pkg::CELL_W-1:0]    cell_value;

	int mismatch_count;
	int results_taken;
	int words_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_wanted = 0;
	int holds_given = 0;
	int hold_left = 0;

	always #10 clk = ~clk;

	text_console_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.char_code(char_code),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cursor_position(cursor_position),
		.cell_value(cell_value)
	);

	text_console_writer_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.char_code(char_code),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cursor_position(cursor_position),
		.cell_value(cell_value),
		.mismatch_count(mismatch_count),
		.results_taken(results_taken)
	);

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (holds_given != holds_wanted) begin
			holds_given++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_word(tcw_pkg::kind_t k, tcw_pkg::char_t c,
		logic [tcw_pkg::INDEX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		char_code  <= c;
		cell_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (results_taken != words_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_color(tcw_pkg::color_t c);
		cfg_write <= 1'b1;
		cfg_data  <= c;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic send_random_word();
		int             r;
		int             p;
		tcw_pkg::char_t c;
		logic [tcw_pkg::INDEX_W-1:0] idx;
		r   = int'($urandom_range(999));
		c   = tcw_pkg::char_t'($urandom_range(255));
		idx = tcw_pkg::INDEX_W'($urandom_range(2047));
		if (r < 800) begin
			p = int'($urandom_range(99));
			if (p < 60)
				c = tcw_pkg::char_t'($urandom_range(tcw_pkg::CHAR_LAST, tcw_pkg::CHAR_SPACE));
			else if (p < 72)
				c = tcw_pkg::CHAR_LF;
			else if (p < 77)
				c = tcw_pkg::CHAR_CR;
			else if (p < 83)
				c = tcw_pkg::CHAR_BS;
			else if (p < 90)
				c = tcw_pkg::CHAR_TAB;
			else if (p < 95)
				c = tcw_pkg::char_t'($urandom_range(tcw_pkg::CHAR_SPACE - 1));
			else
				c = tcw_pkg::char_t'($urandom_range(255, 128));
			send_word(tcw_pkg::KIND_PUT, c, idx);
		end else if (r < 965) begin
			p = int'($urandom_range(99));
			if (p < 70)
				idx = tcw_pkg::INDEX_W'($urandom_range(tcw_pkg::CELL_COUNT - 1));
			else if (p < 90)
				idx = tcw_pkg::INDEX_W'($urandom_range(tcw_pkg::CELL_COUNT - 1,
					tcw_pkg::CELL_COUNT - 3 * tcw_pkg::COLUMNS));
			else
				idx = tcw_pkg::INDEX_W'($urandom_range(2047, tcw_pkg::CELL_COUNT));
			send_word(tcw_pkg::KIND_READ, c, idx);
		end else if (r < 995) begin
			send_word(KIND_UNUSED, c, idx);
		end else begin
			send_word(tcw_pkg::KIND_CLEAR, c, idx);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		kind       = tcw_pkg::KIND_PUT;
		char_code  = '0;
		cell_index = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(tcw_pkg::KIND_READ, 8'h00, 11'd0);
		send_word(tcw_pkg::KIND_READ, 8'hFF, 11'(tcw_pkg::CELL_COUNT - 1));
		send_word(tcw_pkg::KIND_READ, 8'h00, 11'(tcw_pkg::CELL_COUNT));
		send_word(tcw_pkg::KIND_READ, 8'h00, 11'h7FF);
		send_word(KIND_UNUSED, 8'h41, 11'd5);
		send_word(tcw_pkg::KIND_PUT, 8'h41, 11'h7FF);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_LAST, 11'd0);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_SPACE, 11'd0);
		send_word(tcw_pkg::KIND_PUT, 8'h80, 11'd0);
		send_word(tcw_pkg::KIND_PUT, 8'hFF, 11'd0);
		send_word(tcw_pkg::KIND_PUT, 8'h00, 11'd0);
		send_word(tcw_pkg::KIND_PUT, 8'h1F, 11'd0);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_CR, 11'd0);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_BS, 11'd0);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_TAB, 11'd0);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_TAB, 11'd0);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_BS, 11'd0);
		send_word(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_LF, 11'd0);
		send_word(tcw_pkg::KIND_READ, 8'h00, 11'd0);
		send_word(tcw_pkg::KIND_READ, 8'h00, 11'd1);
		send_word(tcw_pkg::KIND_CLEAR, 8'h5A, 11'd3);
		send_word(tcw_pkg::KIND_READ, 8'h00, 11'd0);
		drain();

		write_color(8'h00);
		send_idle_pct = 29;
		recv_idle_pct = 50;
		repeat (PHASE_WORDS) send_random_word();
		drain();

		write_color(8'hFF);
		send_idle_pct = 50;
		recv_idle_pct = 29;
		repeat (PHASE_WORDS) send_random_word();
		drain();

		write_color(tcw_pkg::color_t'($urandom_range(254, 1)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holds_wanted++;
		repeat (PHASE_WORDS) send_random_word();
		drain();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("text_console_writer_tb: done, clean");
		else
			$display("text_console_writer_tb: done, errors");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("text_console_writer_tb: done, errors");
		$finish;
	end

endmodule
